// ===== design/ski_pkg.sv =====
// ----------------------------------------------------------------------------
// ski_pkg: shared definitions for the smootherstep keyframe interpolator
// Default sizes, field counts, curve coefficients, item kinds and the
// sequencer state type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ski_pkg;

  localparam int VALUE_WIDTH_DEF     = 32;
  localparam int BLEND_FRAC_BITS_DEF = 16;

  localparam int DATE_W   = 32;
  localparam int NUM_VALS = 6;
  localparam int VIDX_W   = $clog2(NUM_VALS);

  // shared multiplier: wide operand is one 32-bit slice
  localparam int MUL_A_W = 32;

  // smootherstep 6t^5 - 15t^4 + 10t^3
  localparam int SS_K5 = 6;
  localparam int SS_K4 = 15;
  localparam int SS_K3 = 10;

  // item kind carried on tuser
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLAMP,
    ST_DIV,
    ST_SS_U,
    ST_SS_T2,
    ST_SS_T3,
    ST_SS_S,
    ST_SS_CLAMP,
    ST_V_MAG,
    ST_V_MUL,
    ST_V_ACC,
    ST_V_FIN,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

// ===== design/ski_mul.sv =====
// ----------------------------------------------------------------------------
// ski_mul: shared unsigned multiplier with registered product
// One product per cycle; the result appears in the cycle after the operands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ski_mul #(
  parameter int A_W = ski_pkg::MUL_A_W,
  parameter int B_W = ski_pkg::BLEND_FRAC_BITS_DEF + 1
) (
  input  logic                 clk,
  input  logic [A_W-1:0]       op_a,
  input  logic [B_W-1:0]       op_b,
  output logic [A_W+B_W-1:0]   prod
);

  logic [A_W+B_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= (A_W+B_W)'(op_a) * (A_W+B_W)'(op_b);
  end

  assign prod = prod_r;

endmodule

`default_nettype wire

// ===== design/smoothstep_keyframe_interpolator.sv =====
// ----------------------------------------------------------------------------
// smoothstep_keyframe_interpolator: quintic smootherstep keyframe blender
// Sequence: a query clamps t or runs the bit-serial restoring divide for its
//   F = BLEND_FRAC_BITS quotient bits, then the smootherstep product chain,
//   then one multiply-accumulate per 32-bit slice of each value (NCH slices).
// Flow: items are taken only while idle, so a query finishes and hands its
//   result to the output register before the next item; one shared multiplier.
// Reset: synchronous active-low; both keyframes clear to zero, output empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module smoothstep_keyframe_interpolator #(
  parameter int VALUE_WIDTH     = ski_pkg::VALUE_WIDTH_DEF,
  parameter int BLEND_FRAC_BITS = ski_pkg::BLEND_FRAC_BITS_DEF,
  localparam int TDATA_W =
    ((ski_pkg::DATE_W + ski_pkg::NUM_VALS * VALUE_WIDTH + 7) / 8) * 8
) (
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               in_tvalid,
  output logic               in_tready,
  // frame_date, pos_x, pos_y, pos_z, link_len_a, link_len_b, hand_turn
  input  logic [TDATA_W-1:0] in_tdata,
  // mode
  input  logic               in_tuser,
  // result channel
  output logic               out_tvalid,
  input  logic               out_tready,
  // out_date, out_x, out_y, out_z, out_len_a, out_len_b, out_hand
  output logic [TDATA_W-1:0] out_tdata
);

  localparam int VW     = VALUE_WIDTH;
  localparam int F      = BLEND_FRAC_BITS;
  localparam int DW     = ski_pkg::DATE_W;
  localparam int NV     = ski_pkg::NUM_VALS;
  localparam int IW     = ski_pkg::VIDX_W;
  localparam int AW     = ski_pkg::MUL_A_W;
  localparam int DIFF_W = DW + 1;            // exact date differences
  localparam int T_W    = F + 1;             // blend factor, 0..ONE
  localparam int Q_W    = F + 4;             // up to 15*ONE
  localparam int P_W    = AW + T_W;          // multiplier product
  localparam int NCH    = (VW + AW - 1) / AW; // 32-bit slices per value
  localparam int KW     = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int ACC_W  = NCH * AW + F + 1;
  localparam int CNT_W  = $clog2(F);

  localparam logic [T_W-1:0] ONE_T = T_W'(1) << F;
  localparam logic [Q_W-1:0] ONE_Q = Q_W'(1) << F;
  localparam logic [Q_W-1:0] K4_Q  = Q_W'(ski_pkg::SS_K4) << F;
  localparam logic [Q_W-1:0] K3_Q  = Q_W'(ski_pkg::SS_K3) << F;

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  ski_pkg::state_t state_r, state_nxt;

  // keyframes (reset to zero)
  logic [DW-1:0] start_date_r, end_date_r;
  logic [VW-1:0] start_vals_r [NV];
  logic [VW-1:0] end_vals_r   [NV];

  // query working registers
  logic [DW-1:0]     date_q_r;
  logic [DIFF_W-1:0] n_r, d_r, rem_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [T_W-1:0]    t_r, s_r;
  logic [Q_W-1:0]    q_r;
  logic [VW-1:0]     mag_r;
  logic              up_r;
  logic [ACC_W-1:0]  acc_r;
  logic [KW-1:0]     k_r;
  logic [IW-1:0]     i_r;
  logic [VW-1:0]     res_r [NV];

  // output register
  logic              out_tvalid_r;
  logic [DW-1:0]     out_date_r;
  logic [VW-1:0]     out_vals_r [NV];

  // --------------------------------------------------------------------------
  // Input unpacking and transfer detection
  // --------------------------------------------------------------------------
  logic          in_xfer, load_xfer, query_xfer;
  logic [DW-1:0] in_date;
  logic [VW-1:0] in_vals [NV];

  assign in_tready  = (state_r == ski_pkg::ST_IDLE);
  assign in_xfer    = in_tvalid & in_tready;
  assign load_xfer  = in_xfer & (in_tuser == ski_pkg::MODE_LOAD);
  assign query_xfer = in_xfer & (in_tuser == ski_pkg::MODE_QUERY);
  assign in_date    = in_tdata[DW-1:0];

  always_comb begin
    for (int j = 0; j < NV; j++) begin
      in_vals[j] = in_tdata[DW + j*VW +: VW];
    end
  end

  // --------------------------------------------------------------------------
  // Blend factor: exact differences, clamp decision, restoring divider step
  // --------------------------------------------------------------------------
  logic [DIFF_W-1:0] n_calc, d_calc;
  logic              d_nonpos, n_nonpos, n_ge_d;
  logic [DIFF_W:0]   rem2, rem_sub;
  logic              div_ge;

  assign n_calc = {in_date[DW-1], in_date} - {start_date_r[DW-1], start_date_r};
  assign d_calc = {end_date_r[DW-1], end_date_r} - {start_date_r[DW-1], start_date_r};

  assign d_nonpos = d_r[DIFF_W-1] | (d_r == '0);
  assign n_nonpos = n_r[DIFF_W-1] | (n_r == '0);
  assign n_ge_d   = $signed(n_r) >= $signed(d_r);

  // remainder stays below d, so doubling needs one extra bit
  assign rem2    = {rem_r, 1'b0};
  assign div_ge  = rem2 >= {1'b0, d_r};
  assign rem_sub = rem2 - {1'b0, d_r};

  // --------------------------------------------------------------------------
  // Shared multiplier and its operand selection
  // --------------------------------------------------------------------------
  logic [AW-1:0]       mul_a;
  logic [T_W-1:0]      mul_b;
  logic [P_W-1:0]      mul_prod;
  logic [Q_W-1:0]      six_t;
  logic [Q_W-1:0]      prod_hi_q;   // product / ONE, curve widths
  logic [T_W-1:0]      prod_hi_t;
  logic [T_W-1:0]      s_clamped;
  logic [NCH*AW-1:0]   mag_ext;

  assign six_t     = Q_W'(t_r) * Q_W'(ski_pkg::SS_K5);
  assign prod_hi_q = mul_prod[F +: Q_W];
  assign prod_hi_t = mul_prod[F +: T_W];
  assign s_clamped = (prod_hi_q > ONE_Q) ? ONE_T : prod_hi_q[T_W-1:0];
  assign mag_ext   = (NCH*AW)'(mag_r);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ski_pkg::ST_SS_U: begin       // t * (15 - 6t)
        mul_a = AW'(K4_Q - six_t);
        mul_b = t_r;
      end
      ski_pkg::ST_SS_T2: begin      // t * t
        mul_a = AW'(t_r);
        mul_b = t_r;
      end
      ski_pkg::ST_SS_T3: begin      // t2 * t
        mul_a = AW'(prod_hi_t);
        mul_b = t_r;
      end
      ski_pkg::ST_SS_S: begin       // t3 * q
        mul_a = AW'(q_r);
        mul_b = prod_hi_t;
      end
      ski_pkg::ST_V_MUL: begin      // one slice of |b - a| times s
        mul_a = mag_ext[k_r*AW +: AW];
        mul_b = s_r;
      end
      default: ;
    endcase
  end

  ski_mul #(
    .A_W (AW),
    .B_W (T_W)
  ) u_mul (
    .clk  (clk),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (mul_prod)
  );

  // --------------------------------------------------------------------------
  // Per-value blend: direction, magnitude and final floor-rounded result
  // --------------------------------------------------------------------------
  logic [VW-1:0] val_a, val_b, mag_w, q_val, res_w;
  logic          up_w, rem_bit;

  assign val_a   = start_vals_r[i_r];
  assign val_b   = end_vals_r[i_r];
  assign up_w    = $signed(val_b) >= $signed(val_a);
  assign mag_w   = up_w ? (val_b - val_a) : (val_a - val_b);
  assign q_val   = acc_r[F +: VW];
  assign rem_bit = |acc_r[F-1:0];
  // falling blends round the magnitude up so the result floors
  assign res_w   = up_r ? (val_a + q_val) : (val_a - q_val - VW'(rem_bit));

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  logic done_go;

  assign done_go = (state_r == ski_pkg::ST_DONE) & (~out_tvalid_r | out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ski_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ski_pkg::ST_IDLE: begin
        if (query_xfer) state_nxt = ski_pkg::ST_CLAMP;
      end
      ski_pkg::ST_CLAMP: begin
        if (d_nonpos || n_nonpos || n_ge_d) state_nxt = ski_pkg::ST_SS_U;
        else                                state_nxt = ski_pkg::ST_DIV;
      end
      ski_pkg::ST_DIV: begin
        if (cnt_r == CNT_W'(F - 1)) state_nxt = ski_pkg::ST_SS_U;
      end
      ski_pkg::ST_SS_U:     state_nxt = ski_pkg::ST_SS_T2;
      ski_pkg::ST_SS_T2:    state_nxt = ski_pkg::ST_SS_T3;
      ski_pkg::ST_SS_T3:    state_nxt = ski_pkg::ST_SS_S;
      ski_pkg::ST_SS_S:     state_nxt = ski_pkg::ST_SS_CLAMP;
      ski_pkg::ST_SS_CLAMP: state_nxt = ski_pkg::ST_V_MAG;
      ski_pkg::ST_V_MAG:    state_nxt = ski_pkg::ST_V_MUL;
      ski_pkg::ST_V_MUL:    state_nxt = ski_pkg::ST_V_ACC;
      ski_pkg::ST_V_ACC: begin
        if (k_r == KW'(NCH - 1)) state_nxt = ski_pkg::ST_V_FIN;
        else                     state_nxt = ski_pkg::ST_V_MUL;
      end
      ski_pkg::ST_V_FIN: begin
        if (i_r == IW'(NV - 1)) state_nxt = ski_pkg::ST_DONE;
        else                    state_nxt = ski_pkg::ST_V_MAG;
      end
      ski_pkg::ST_DONE: begin
        if (done_go) state_nxt = ski_pkg::ST_IDLE;
      end
      default: state_nxt = ski_pkg::ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Keyframe store and output valid (reset state)
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_date_r <= '0;
      end_date_r   <= '0;
      for (int j = 0; j < NV; j++) begin
        start_vals_r[j] <= '0;
        end_vals_r[j]   <= '0;
      end
      out_tvalid_r <= 1'b0;
    end else begin
      // load: end frame slides into start, new frame becomes end
      if (load_xfer) begin
        start_date_r <= end_date_r;
        end_date_r   <= in_date;
        for (int j = 0; j < NV; j++) begin
          start_vals_r[j] <= end_vals_r[j];
          end_vals_r[j]   <= in_vals[j];
        end
      end
      if (done_go) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Working datapath registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    case (state_r)
      ski_pkg::ST_IDLE: begin
        if (in_xfer) begin
          date_q_r <= in_date;
          n_r      <= n_calc;
          d_r      <= d_calc;
        end
      end
      ski_pkg::ST_CLAMP: begin
        rem_r <= n_r;
        cnt_r <= '0;
        // quotient bits shift in from zero when the divide runs
        t_r   <= (d_nonpos || n_ge_d) ? ONE_T : '0;
      end
      ski_pkg::ST_DIV: begin
        t_r   <= {t_r[T_W-2:0], div_ge};
        rem_r <= div_ge ? rem_sub[DIFF_W-1:0] : rem2[DIFF_W-1:0];
        cnt_r <= cnt_r + CNT_W'(1);
      end
      ski_pkg::ST_SS_T2: begin
        q_r <= K3_Q - prod_hi_q;
      end
      ski_pkg::ST_SS_CLAMP: begin
        s_r <= s_clamped;
        i_r <= '0;
      end
      ski_pkg::ST_V_MAG: begin
        mag_r <= mag_w;
        up_r  <= up_w;
        acc_r <= '0;
        k_r   <= '0;
      end
      ski_pkg::ST_V_ACC: begin
        acc_r <= acc_r + (ACC_W'(mul_prod) << (k_r * AW));
        k_r   <= k_r + KW'(1);
      end
      ski_pkg::ST_V_FIN: begin
        res_r[i_r] <= res_w;
        i_r        <= i_r + IW'(1);
      end
      ski_pkg::ST_DONE: begin
        if (done_go) begin
          out_date_r <= date_q_r;
          for (int j = 0; j < NV; j++) begin
            out_vals_r[j] <= res_r[j];
          end
        end
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Output packing
  // --------------------------------------------------------------------------
  assign out_tvalid = out_tvalid_r;

  always_comb begin
    out_tdata         = '0;
    out_tdata[DW-1:0] = out_date_r;
    for (int j = 0; j < NV; j++) begin
      out_tdata[DW + j*VW +: VW] = out_vals_r[j];
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
`ifndef ASSERT_OFF
  // shaped factor never exceeds one while the blends run
  a_s_le_one: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ski_pkg::ST_V_MUL) |-> (s_r <= ONE_T))
    else $error("shaped blend factor above one");

  // divider remainder stays below the interval
  a_rem_lt_d: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ski_pkg::ST_DIV) |-> (rem_r < d_r))
    else $error("divider remainder not below interval");

  // a result only appears after the sequencer has finished a query
  a_valid_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(state_r == ski_pkg::ST_DONE))
    else $error("result raised outside completion");

  // a query transfer always starts the sequencer
  a_query_starts: assert property (@(posedge clk) disable iff (!rst_n)
    query_xfer |=> (state_r == ski_pkg::ST_CLAMP))
    else $error("query transfer did not start sequencer");

  // a load never disturbs the sequencer
  a_load_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
    load_xfer |=> (state_r == ski_pkg::ST_IDLE))
    else $error("load transfer left idle");
`endif

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: smoothstep keyframe interpolator
// Directed rows, then about 1300 random transfers. Every query result is
// checked word by word against an in-bench keyframe blender or a typed row's
// expectation, under several sender and receiver idling patterns and one long output hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam int VAL_W    = ski_pkg::VALUE_WIDTH_DEF;
  localparam int BLEND_F  = ski_pkg::BLEND_FRAC_BITS_DEF;
  localparam int NUM_VALS = ski_pkg::NUM_VALS;
  localparam int TDATA_W  = ((ski_pkg::DATE_W + NUM_VALS * VAL_W + 7) / 8) * 8;
  localparam int NWORDS   = NUM_VALS + 1;       // date plus six values

  localparam bit [63:0] ONE_T = 64'd1 << BLEND_F;

  localparam int CYCLE_LIMIT  = 400000;         // far beyond the slowest legal run
  localparam int DRAIN_CYCLES = 60;             // settle time after the last result
  localparam int HOLD_CYCLES  = 800;            // long output hold-off
  localparam int PHASE_ITEMS  = 305;
  localparam int FILL_ITEMS   = 80;

  // one input transfer: word 0 is the date, words 1..6 the keyframe values
  typedef struct packed {
    logic                   mode;
    logic [NWORDS-1:0][31:0] words;
  } stim_item_t;

  // a directed row; 'typed' rows carry their expected values by hand
  typedef struct {
    stim_item_t              item;
    bit                      typed;
    logic [NUM_VALS-1:0][31:0] known;
  } stim_row_t;

  localparam logic [NUM_VALS-1:0][31:0] ZERO6 = '0;
  localparam logic [NUM_VALS-1:0][31:0] ONES6 = '1;
  // packed lists read from hand_turn down to pos_x
  localparam logic [NUM_VALS-1:0][31:0] FRAME_A =
    {32'h12345678, 32'h00000001, 32'hFFFFFFFF, 32'h00000000, 32'h80000000, 32'h7FFFFFFF};
  localparam logic [NUM_VALS-1:0][31:0] FRAME_B =
    {32'h80000000, 32'h7FFFFFFF, 32'h00000000, 32'hFFFFFFFF, 32'h7FFFFFFF, 32'h80000000};
  localparam logic [NUM_VALS-1:0][31:0] FRAME_C =
    {32'hA5A5A5A5, 32'h5A5A5A5A, 32'h0000FFFF, 32'hFFFF0000, 32'h00010000, 32'hFFFEFFFF};

  logic               clk        = 1'b0;
  logic               rst_n      = 1'b0;
  logic               in_tvalid  = 1'b0;
  logic               in_tready;
  logic [TDATA_W-1:0] in_tdata   = '0;
  logic               in_tuser   = ski_pkg::MODE_LOAD;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [TDATA_W-1:0] out_tdata;

  // keyframe state of the in-bench blender
  logic [31:0]               kf_start_date;
  logic [31:0]               kf_end_date;
  logic [NUM_VALS-1:0][31:0] kf_start_vals;
  logic [NUM_VALS-1:0][31:0] kf_end_vals;

  logic [TDATA_W-1:0] pending_results[$];
  int                 mismatch_count = 0;
  int                 cycle_count    = 0;

  // idling knobs, percent per cycle
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // output hold-off, owned by the receiver process
  bit hold_request = 1'b0;
  bit hold_taken   = 1'b0;
  int hold_left    = 0;

  stim_row_t directed_rows[$];

  smoothstep_keyframe_interpolator i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),     // date, x, y, z, len_a, len_b, hand
    .in_tuser   (in_tuser),     // mode
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)     // date, x, y, z, len_a, len_b, hand
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Keyframe blender
  // --------------------------------------------------------------------------

  // Q1.F position of the query date between the two keyframe dates.
  // A non-positive interval (reset state too) pins t to one.
  function automatic bit [63:0] blend_factor(logic [31:0] qdate);
    longint num, den;
    num = longint'($signed(qdate)) - longint'($signed(kf_start_date));
    den = longint'($signed(kf_end_date)) - longint'($signed(kf_start_date));
    if (den <= 0) return ONE_T;
    if (num <= 0) return 64'd0;
    if (num >= den) return ONE_T;
    return (num * longint'(ONE_T)) / den;
  endfunction

  // 6t^5 - 15t^4 + 10t^3 as t^3 * (10 - t*(15 - 6t)), truncating at each step
  function automatic bit [63:0] smootherstep(bit [63:0] t);
    bit [63:0] u, q, t2, t3, s;
    u = (t * (15 * ONE_T - 6 * t)) >> BLEND_F;
    if (u > 10 * ONE_T) return 64'd0;
    q  = 10 * ONE_T - u;
    t2 = (t * t) >> BLEND_F;
    t3 = (t2 * t) >> BLEND_F;
    s  = (t3 * q) >> BLEND_F;
    if (s > ONE_T) s = ONE_T;
    return s;
  endfunction

  // a + floor((b - a) * s / ONE), floor towards minus infinity
  function automatic logic [31:0] blend_value(logic [31:0] a, logic [31:0] b, bit [63:0] s);
    longint      diff, step;
    logic [63:0] sum;
    diff = longint'($signed(b)) - longint'($signed(a));
    step = (diff * longint'(s)) >>> BLEND_F;
    sum  = longint'($signed(a)) + step;
    return sum[31:0];
  endfunction

  function automatic logic [TDATA_W-1:0] interpolate_query(logic [31:0] qdate);
    bit [63:0]               s;
    logic [NWORDS-1:0][31:0] r;
    s    = smootherstep(blend_factor(qdate));
    r[0] = qdate;
    for (int k = 0; k < NUM_VALS; k++)
      r[k+1] = blend_value(kf_start_vals[k], kf_end_vals[k], s);
    return r;
  endfunction

  // end frame slides into the start slot, new frame becomes the end
  function automatic void load_keyframe(stim_item_t it);
    kf_start_date = kf_end_date;
    kf_start_vals = kf_end_vals;
    kf_end_date   = it.words[0];
    for (int k = 0; k < NUM_VALS; k++)
      kf_end_vals[k] = it.words[k+1];
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  function automatic stim_row_t mk_row(logic mode, logic [31:0] date,
                                       logic [NUM_VALS-1:0][31:0] vals, bit typed,
                                       logic [NUM_VALS-1:0][31:0] known);
    stim_row_t r;
    r.item.mode  = mode;
    r.item.words = {vals, date};
    r.typed      = typed;
    r.known      = known;
    return r;
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 19))
      0:       return 32'h7FFFFFFF;
      1:       return 32'h80000000;
      2:       return 32'h00000000;
      3:       return 32'hFFFFFFFF;
      default: return $urandom;
    endcase
  endfunction

  // Loads mostly move forward in time so queries land inside a real
  // interval; the rest give zero, reversed or wild intervals.
  function automatic stim_item_t random_item();
    stim_item_t  it;
    int          pick;
    logic [31:0] span;
    bit          forward;
    it.mode = ($urandom_range(0, 99) < 30) ? ski_pkg::MODE_LOAD : ski_pkg::MODE_QUERY;
    for (int k = 1; k < NWORDS; k++)
      it.words[k] = rand_word();
    pick    = $urandom_range(0, 99);
    span    = kf_end_date - kf_start_date;
    forward = longint'($signed(kf_end_date)) > longint'($signed(kf_start_date));
    if (it.mode == ski_pkg::MODE_LOAD) begin
      if (pick < 75)      it.words[0] = kf_end_date + $urandom_range(1, 200000);
      else if (pick < 85) it.words[0] = kf_end_date;
      else if (pick < 92) it.words[0] = kf_end_date - $urandom_range(1, 1000);
      else                it.words[0] = $urandom;
    end else begin
      if (pick < 70 && forward) begin
        it.words[0] = kf_start_date + $urandom_range(0, span);
      end else if (pick < 85) begin
        case ($urandom_range(0, 3))
          0:       it.words[0] = kf_start_date - 1;
          1:       it.words[0] = kf_start_date;
          2:       it.words[0] = kf_end_date;
          default: it.words[0] = kf_end_date + 1;
        endcase
      end else begin
        it.words[0] = $urandom;
      end
    end
    return it;
  endfunction

  // Offer one item, wait for its transfer, then update the blender.
  // in_tvalid is left high; the next call either idles or re-offers.
  task automatic transfer_item(stim_item_t it, bit typed,
                               logic [NUM_VALS-1:0][31:0] known);
    logic [TDATA_W-1:0] want;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= it.words;
    in_tuser  <= it.mode;
    do @(posedge clk); while (!in_tready);
    if (it.mode == ski_pkg::MODE_LOAD) begin
      load_keyframe(it);
    end else begin
      want = interpolate_query(it.words[0]);
      if (typed) want = {known, it.words[0]};
      pending_results.push_back(want);
    end
  endtask

  task automatic random_phase(int count, int idle_pct, int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) transfer_item(random_item(), 1'b0, ZERO6);
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random stalls, plus one long hold-off on request
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_request && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Result checker: each output transfer against the oldest expectation
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    logic [TDATA_W-1:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("ERROR: unexpected result %h", out_tdata);
      end else begin
        want = pending_results.pop_front();
        for (int k = 0; k < NWORDS; k++) begin
          if (out_tdata[32*k +: 32] !== want[32*k +: 32]) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("ERROR: word %0d (0=date, 1..6=x,y,z,len_a,len_b,hand): exp %h got %h",
                       k, want[32*k +: 32], out_tdata[32*k +: 32]);
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("smoothstep_keyframe_interpolator verification failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    kf_start_date = '0;
    kf_end_date   = '0;
    kf_start_vals = '0;
    kf_end_vals   = '0;

    // Directed rows. Typed expectations are the obvious ones: zeros after
    // reset, or one keyframe exactly when t clamps or the interval is empty.
    // Reset state: empty interval, everything blends to the zero end frame
    directed_rows.push_back(mk_row(ski_pkg::MODE_QUERY, 32'h00000000, ZERO6,   1, ZERO6));
    directed_rows.push_back(mk_row(ski_pkg::MODE_QUERY, 32'h7FFFFFFF, ONES6,   1, ZERO6));
    directed_rows.push_back(mk_row(ski_pkg::MODE_QUERY, 32'h80000000, ZERO6,   1, ZERO6));
    // both keyframes on date 0: empty interval, end frame wins
    directed_rows.push_back(mk_row(ski_pkg::MODE_LOAD,  32'h00000000, FRAME_A, 0, ZERO6));
    directed_rows.push_back(mk_row(ski_pkg::MODE_QUERY, 32'd123,      ZERO6,   1, FRAME_A));
    // proper interval 0..1000, A to B
    directed_rows.push_back(mk_row(ski_pkg::MODE_LOAD,  32'd1000,     FRAME_B, 0, ZERO6));
    directed_rows.push_back(mk_row(ski_pkg::MODE_QUERY, 32'hFFFFFFFB, ZERO6,   1, FRAME_A));
    directed_rows.push_back(mk_row(ski_pkg::MODE_QUERY, 32'd0,        ZERO6,   1, FRAME_A));
    directed_rows.push_back(mk_row(ski_pkg::MODE_QUERY, 32'd1000,     ZERO6,   1, FRAME_B));
    directed_rows.push_back(mk_row(ski_pkg::MODE_QUERY, 32'd5000,     ZERO6,   1, FRAME_B));
    directed_rows.push_back(mk_row(ski_pkg::MODE_QUERY, 32'd500,      ZERO6,   0, ZERO6));
    directed_rows.push_back(mk_row(ski_pkg::MODE_QUERY, 32'd1,        ZERO6,   0, ZERO6));
    directed_rows.push_back(mk_row(ski_pkg::MODE_QUERY, 32'd999,      FRAME_C, 0, ZERO6));
    // repeated date: zero-length interval
    directed_rows.push_back(mk_row(ski_pkg::MODE_LOAD,  32'd1000,     FRAME_C, 0, ZERO6));
    directed_rows.push_back(mk_row(ski_pkg::MODE_QUERY, 32'd2000,     ZERO6,   1, FRAME_C));
    directed_rows.push_back(mk_row(ski_pkg::MODE_QUERY, 32'h80000000, ZERO6,   1, FRAME_C));
    // end date before start date: negative interval
    directed_rows.push_back(mk_row(ski_pkg::MODE_LOAD,  32'd0,        FRAME_A, 0, ZERO6));
    directed_rows.push_back(mk_row(ski_pkg::MODE_QUERY, 32'd500,      ZERO6,   1, FRAME_A));
    // widest interval, most negative to most positive date
    directed_rows.push_back(mk_row(ski_pkg::MODE_LOAD,  32'h80000000, FRAME_B, 0, ZERO6));
    directed_rows.push_back(mk_row(ski_pkg::MODE_LOAD,  32'h7FFFFFFF, FRAME_C, 0, ZERO6));
    directed_rows.push_back(mk_row(ski_pkg::MODE_QUERY, 32'd0,        ZERO6,   0, ZERO6));
    directed_rows.push_back(mk_row(ski_pkg::MODE_QUERY, 32'h7FFFFFFF, ZERO6,   1, FRAME_C));
    directed_rows.push_back(mk_row(ski_pkg::MODE_QUERY, 32'h80000000, ZERO6,   1, FRAME_B));
    directed_rows.push_back(mk_row(ski_pkg::MODE_QUERY, 32'd1,        ZERO6,   0, ZERO6));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i])
      transfer_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].known);

    // fill-up: output held off while the sender keeps offering
    hold_request = 1'b1;
    random_phase(FILL_ITEMS, 0, 0);

    random_phase(PHASE_ITEMS, 0, 0);
    random_phase(PHASE_ITEMS, 75, 0);
    random_phase(PHASE_ITEMS, 0, 75);
    random_phase(PHASE_ITEMS, 26, 26);

    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("smoothstep_keyframe_interpolator verification clean");
    end else begin
      $display("smoothstep_keyframe_interpolator verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/ski_pkg.sv
design/ski_mul.sv
design/smoothstep_keyframe_interpolator.sv
tb/testbench.sv
